@@ rtl/tkri_pkg.sv @@
// Shared constants and ranking compare for the top-k ranked insert table.
package tkri_pkg;

    localparam int ENTRIES_DEF     = 10;
    localparam int PLAYER_BITS_DEF = 16;

    localparam int PID_W   = 16;
    localparam int LEVEL_W = 16;
    localparam int TIME_W  = 32;
    localparam int RANK_W  = 6;

    // true when (lv, tm) ranks strictly before (slv, stm)
    function automatic logic ranks_before(
        input logic [LEVEL_W-1:0] lv,
        input logic [TIME_W-1:0]  tm,
        input logic [LEVEL_W-1:0] slv,
        input logic [TIME_W-1:0]  stm
    );
        logic r;
        if (lv != slv)
        begin
            r = (lv > slv);
        end
        else
        begin
            r = (tm < stm);
        end
        return r;
    endfunction

endpackage

@@ rtl/tkri_table.sv @@
// Ranked table storage: one write port, one registered read port.
module tkri_table #(
    parameter int W     = 64,
    parameter int DEPTH = 10,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/top_k_ranked_insert_top.sv @@
// Top-k ranked insert table: top level with the insert-and-dump sequencer.
//
// Pulse start while busy is low to insert one record. The block then walks
// the ranked table once, best first, reading each stored word, placing the
// new record where it ranks and pushing the rest down by one. Every table
// word after the insert comes out on the result ports for one cycle with
// strobe high, in rank order; is_new marks the inserted record and last
// marks the final word. An insert into a table holding n records keeps busy
// high while it walks rows 0 to n, or all rows when the table is full, one row
// per walk cycle. Each word appears in the cycle after its walk cycle, so the
// last word is on the ports in the first cycle with busy low, and the next start
// can be taken at the end of that cycle. Results cannot be held off.
module top_k_ranked_insert_top #(
    parameter int ENTRIES     = tkri_pkg::ENTRIES_DEF,
    parameter int PLAYER_BITS = tkri_pkg::PLAYER_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tkri_pkg::PID_W-1:0]    player_id,
    input  logic [tkri_pkg::LEVEL_W-1:0]  level,
    input  logic [tkri_pkg::TIME_W-1:0]   time_ms,
    output logic                          strobe,
    output logic [tkri_pkg::RANK_W-1:0]   rank,
    output logic [tkri_pkg::PID_W-1:0]    entry_player,
    output logic [tkri_pkg::LEVEL_W-1:0]  entry_level,
    output logic [tkri_pkg::TIME_W-1:0]   entry_time_ms,
    output logic                          is_new,
    output logic                          last
);

    localparam int PW = (PLAYER_BITS < tkri_pkg::PID_W) ? PLAYER_BITS : tkri_pkg::PID_W;
    localparam int LW = tkri_pkg::LEVEL_W;
    localparam int TW = tkri_pkg::TIME_W;
    localparam int EW = PW + LW + TW;
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] nlast_reg, nlast_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ins_reg, ins_next;
    logic [EW-1:0] carry_reg, carry_next;
    logic [EW-1:0] new_reg, new_next;

    logic                strobe_reg, strobe_next;
    logic [tkri_pkg::RANK_W-1:0] rank_reg, rank_next;
    logic [EW-1:0]       word_reg, word_next;
    logic                is_new_reg, is_new_next;
    logic                last_reg, last_next;

    logic          accept;
    logic          run;
    logic [EW-1:0] old_word;
    logic          have_old;
    logic          new_ahead;
    logic          take_new;
    logic          at_last;
    logic          we;
    logic [EW-1:0] wdata;
    logic          re;
    logic [IW-1:0] raddr;
    logic [IW:0]   idx_inc;

    assign accept    = start && (state_reg == S_IDLE);
    assign run       = (state_reg == S_RUN);
    assign busy      = run;
    assign have_old  = (CW'(idx_reg) < cnt_reg);
    assign new_ahead = tkri_pkg::ranks_before(new_reg[TW +: LW], new_reg[TW-1:0],
                                              old_word[TW +: LW], old_word[TW-1:0]);
    assign take_new  = !ins_reg && (!have_old || new_ahead);
    assign at_last   = (idx_reg == nlast_reg);
    assign idx_inc   = {1'b0, idx_reg} + (IW+1)'(1);

    assign we    = run && (ins_reg || take_new);
    assign wdata = ins_reg ? carry_reg : (take_new ? new_reg : old_word);
    assign re    = accept || (run && !at_last);
    assign raddr = accept ? '0 : idx_inc[IW-1:0];

    // reads run one row ahead of writes, so a row is never read and written together
    tkri_table #(
        .W     (EW),
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (idx_reg),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (old_word)
    );

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        nlast_next  = nlast_reg;
        cnt_next    = cnt_reg;
        ins_next    = ins_reg;
        carry_next  = carry_reg;
        new_next    = new_reg;
        strobe_next = 1'b0;
        rank_next   = rank_reg;
        word_next   = word_reg;
        is_new_next = is_new_reg;
        last_next   = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    new_next   = {PW'(player_id), level, time_ms};
                    idx_next   = '0;
                    ins_next   = 1'b0;
                    nlast_next = (cnt_reg == CW'(ENTRIES)) ? IW'(ENTRIES - 1)
                                                           : cnt_reg[IW-1:0];
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                strobe_next = 1'b1;
                rank_next   = tkri_pkg::RANK_W'(idx_reg);
                word_next   = wdata;
                is_new_next = take_new;
                last_next   = at_last;
                if (ins_reg || take_new)
                begin
                    carry_next = old_word;
                    ins_next   = 1'b1;
                end
                idx_next = idx_inc[IW-1:0];
                if (at_last)
                begin
                    state_next = S_IDLE;
                    if (cnt_reg != CW'(ENTRIES))
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
            idx_reg    <= '0;
            nlast_reg  <= '0;
            ins_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
            idx_reg    <= idx_next;
            nlast_reg  <= nlast_next;
            ins_reg    <= ins_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg  <= carry_next;
        new_reg    <= new_next;
        rank_reg   <= rank_next;
        word_reg   <= word_next;
        is_new_reg <= is_new_next;
        last_reg   <= last_next;
    end

    assign strobe        = strobe_reg;
    assign rank          = rank_reg;
    assign entry_player  = tkri_pkg::PID_W'(word_reg[EW-1 -: PW]);
    assign entry_level   = word_reg[TW +: LW];
    assign entry_time_ms = word_reg[TW-1:0];
    assign is_new        = is_new_reg;
    assign last          = last_reg;

    a_strobe_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(state_reg == S_RUN))
        else $error("result word without a walk cycle");

    a_rank_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && (rank_reg != '0)) |-> $past(strobe_reg))
        else $error("dump word out of sequence");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(ENTRIES))
        else $error("record count overflow");

    a_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (run && (CW'(idx_reg) <= cnt_reg)))
        else $error("table write outside the filled prefix");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && last_reg) |=> !strobe_reg)
        else $error("word after last of dump");

endmodule
